[sv/lcgsm_pkg.sv]
// Package: shared constants for the drand48 seed sequence matcher.
`timescale 1ns / 1ps
package lcgsm_pkg;
  localparam int SEQ_LEN   = 256;
  localparam int TBL_AW    = 8;
  localparam int TBL_DEPTH = 1 << TBL_AW;
  localparam int CNT_W     = $clog2(SEQ_LEN + 1);
  localparam int X_W       = 48;
  localparam int HALF_W    = X_W / 2;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 8;

  localparam logic [HALF_W-1:0] LCG_MUL_LO = 24'hECE66D;
  localparam logic [HALF_W-1:0] LCG_MUL_HI = 24'h0005DE;
  localparam logic [X_W-1:0]    LCG_ADD    = 48'hB;
  localparam logic [15:0]       SEED_LOW   = 16'h330E;
  localparam int TOP_SHIFT = 40;
  localparam int LOW_SHIFT = 17;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TEST = 1'b1;

  typedef logic [X_W-1:0] lcg_state_t;
endpackage

[sv/lcgsm_step.sv]
// One LCG step x*a+c mod 2^48 in three passes through a shared 24x24 multiplier.
`timescale 1ns / 1ps
module lcgsm_step (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  lcgsm_pkg::lcg_state_t x_in,
  output logic                 done,
  output lcgsm_pkg::lcg_state_t x_out
);
  import lcgsm_pkg::*;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_LL   = 2'd1;
  localparam logic [1:0] PH_LH   = 2'd2;
  localparam logic [1:0] PH_HL   = 2'd3;

  logic [1:0]        phase_r, phase_nxt;
  logic              done_r, done_nxt;
  lcg_state_t        xs_r, acc_r, acc_nxt;
  logic [HALF_W-1:0] mul_a, mul_b;
  logic [X_W-1:0]    prod;

  assign mul_a = (phase_r == PH_HL) ? xs_r[X_W-1:HALF_W] : xs_r[HALF_W-1:0];
  assign mul_b = (phase_r == PH_LH) ? LCG_MUL_HI : LCG_MUL_LO;
  assign prod  = X_W'(mul_a) * X_W'(mul_b);

  always_comb begin
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    done_nxt  = 1'b0;
    case (phase_r)
      PH_IDLE: begin
        if (start) phase_nxt = PH_LL;
      end
      PH_LL: begin
        acc_nxt   = prod + LCG_ADD;
        phase_nxt = PH_LH;
      end
      PH_LH: begin
        acc_nxt   = acc_r + {prod[HALF_W-1:0], {HALF_W{1'b0}}};
        phase_nxt = PH_HL;
      end
      PH_HL: begin
        acc_nxt   = acc_r + {prod[HALF_W-1:0], {HALF_W{1'b0}}};
        phase_nxt = PH_IDLE;
        done_nxt  = 1'b1;
      end
      default: phase_nxt = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      done_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    if (phase_r == PH_IDLE && start) xs_r <= x_in;
  end

  assign done  = done_r;
  assign x_out = acc_r;
endmodule

[sv/lcg48_seed_sequence_matcher.sv]
// Top level: drand48 seed checker against a 256-entry target byte table.
//
//   channel | dir | handshake          | payload
//   in_     | in  | tvalid/tready      | tuser: op; tdata: seed, target_index, target_byte
//   out_    | out | tvalid/tready      | tdata: top_byte_match, low_byte_match
//
// A load word is written to the table on acceptance. A test word runs one LCG step at a
// time (table read plus three passes through the shared 24x24 multiplier plus compare),
// stopping at the first step where both flags have failed or after SEQ_LEN steps.
// Reset clears control state only; the table holds garbage until loaded.
// A result not yet taken holds the next finished test in S_OUT, with in_tready low.
`timescale 1ns / 1ps
module lcg48_seed_sequence_matcher (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [lcgsm_pkg::IN_DATA_W-1:0]  in_tdata,  // seed[31:0], target_index, target_byte
  input  logic                             in_tuser,  // op
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [lcgsm_pkg::OUT_DATA_W-1:0] out_tdata  // top_byte_match, low_byte_match, zeros
);
  import lcgsm_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_LAUNCH = 3'd1;
  localparam logic [2:0] S_WAIT   = 3'd2;
  localparam logic [2:0] S_OUT    = 3'd3;
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(SEQ_LEN - 1);

  logic [2:0]        state_r, state_nxt;
  lcg_state_t        x_r, x_nxt, step_x;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [TBL_AW-1:0] idx_r, idx_nxt;
  logic              top_ok_r, top_ok_nxt, low_ok_r, low_ok_nxt;
  logic              out_tvalid_r, out_tvalid_nxt;
  logic [1:0]        out_flags_r, out_flags_nxt;
  logic [7:0]        tbl [TBL_DEPTH];
  logic [7:0]        rd_r;
  logic              step_done, top_hit, low_hit, accept;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;

  lcgsm_step u_step (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == S_LAUNCH),
    .x_in  (x_r),
    .done  (step_done),
    .x_out (step_x)
  );

  assign top_hit = (step_x[TOP_SHIFT +: 8] == rd_r);
  assign low_hit = (step_x[LOW_SHIFT +: 8] == rd_r);

  always_comb begin
    state_nxt      = state_r;
    x_nxt          = x_r;
    cnt_nxt        = cnt_r;
    idx_nxt        = idx_r;
    top_ok_nxt     = top_ok_r;
    low_ok_nxt     = low_ok_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_flags_nxt  = out_flags_r;
    case (state_r)
      S_IDLE: begin
        if (accept && in_tuser == OP_TEST) begin
          x_nxt      = {in_tdata[31:0], SEED_LOW};
          cnt_nxt    = '0;
          idx_nxt    = '0;
          top_ok_nxt = 1'b1;
          low_ok_nxt = 1'b1;
          state_nxt  = S_LAUNCH;
        end
      end
      S_LAUNCH: state_nxt = S_WAIT;
      S_WAIT: begin
        if (step_done) begin
          x_nxt      = step_x;
          top_ok_nxt = top_ok_r && top_hit;
          low_ok_nxt = low_ok_r && low_hit;
          cnt_nxt    = cnt_r + CNT_W'(1);
          idx_nxt    = idx_r + TBL_AW'(1);
          if (cnt_r == LAST_CNT || !(top_ok_nxt || low_ok_nxt)) state_nxt = S_OUT;
          else state_nxt = S_LAUNCH;
        end
      end
      S_OUT: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_flags_nxt  = {low_ok_r, top_ok_r};
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r         <= x_nxt;
    cnt_r       <= cnt_nxt;
    idx_r       <= idx_nxt;
    top_ok_r    <= top_ok_nxt;
    low_ok_r    <= low_ok_nxt;
    out_flags_r <= out_flags_nxt;
  end

  // target table: one write port for loads, one registered read port
  always_ff @(posedge clk) begin
    if (accept && in_tuser == OP_LOAD) tbl[in_tdata[39:32]] <= in_tdata[47:40];
    rd_r <= tbl[idx_r];
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(OUT_DATA_W-2){1'b0}}, out_flags_r};
endmodule
